// File: hw/rtl/ctrc_pkg.sv
// ----------------------------------------------------------------------------
// ctrc_pkg
// Shared types and constants for the current triggered relay controller.
// ----------------------------------------------------------------------------
package ctrc_pkg;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 24;
  localparam int unsigned MA_W        = 13;
  localparam int unsigned INTERVAL_W  = 16;
  localparam int unsigned WINDOW_W    = 10;
  localparam int unsigned PHASE_W     = 10;

  // Register indexes on the configuration channel.
  localparam logic [CFG_INDEX_W-1:0] CFG_TRIGGER_MA   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_INTERVAL_MS  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_MS    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_FOLLOWER_LAG = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_PULSE_LAG    = 3'd4;

  localparam logic [MA_W-1:0]       TRIGGER_RESET  = 13'd250;
  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd5000;
  localparam logic [WINDOW_W-1:0]   WINDOW_RESET   = 10'd100;
  localparam int unsigned           FOLLOWER_LAG_RESET = 5000;
  localparam int unsigned           PULSE_LAG_RESET    = 500;
  // Reset lags need this many bits even for narrow lag configurations.
  localparam int unsigned           LAG_RESET_W = 13;

  // 20000 mA full scale times 0.3536 for the peak-to-peak to RMS conversion.
  localparam int unsigned RMS_FULL_SCALE = 7072;

  // Blink pattern over a 1000 ms period.
  localparam logic [PHASE_W-1:0] PHASE_LAST  = 10'd999;
  localparam logic [PHASE_W-1:0] LED_ON_END  = 10'd250;
  localparam logic [PHASE_W-1:0] LED_MID_LO  = 10'd500;
  localparam logic [PHASE_W-1:0] LED_MID_HI  = 10'd750;

  typedef struct packed {
    logic            close;      // a tick closed the sampling window
    logic            idle_tick;  // a tick arrived outside a window
    logic [MA_W-1:0] milliamps;  // measurement after this step
  } win_evt_t;

  typedef struct packed {
    logic follower_relay;
    logic follower_led;
    logic pulse_relay;
    logic pulse_led;
  } relay_out_t;

endpackage

// File: hw/rtl/ctrc_if.sv
// ----------------------------------------------------------------------------
// ctrc interfaces
// Valid/ready channels for samples and ticks, results and register writes.
// ----------------------------------------------------------------------------
interface ctrc_in_if #(
  parameter int unsigned ADC_BITS = 10
);
  logic                valid;
  logic                ready;
  logic                action;
  logic [ADC_BITS-1:0] adc_sample;

  modport source (output valid, action, adc_sample, input ready);
  modport sink   (input valid, action, adc_sample, output ready);
endinterface

interface ctrc_out_if;
  logic                       valid;
  logic                       ready;
  logic                       follower_relay;
  logic                       follower_led;
  logic                       pulse_relay;
  logic                       pulse_led;
  logic [ctrc_pkg::MA_W-1:0]  measured_milliamps;
  logic                       measurement_done;

  modport source (output valid, follower_relay, follower_led, pulse_relay, pulse_led,
                  measured_milliamps, measurement_done, input ready);
  modport sink   (input valid, follower_relay, follower_led, pulse_relay, pulse_led,
                  measured_milliamps, measurement_done, output ready);
endinterface

interface ctrc_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [ctrc_pkg::CFG_INDEX_W-1:0] index;
  logic [ctrc_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: hw/rtl/current_triggered_relay_controller_top.sv
// ----------------------------------------------------------------------------
// current_triggered_relay_controller_top
// Current sensing relay controller with lagged follower and shutoff pulse.
// ----------------------------------------------------------------------------
// Each transaction on the input channel is an ADC sample or a millisecond tick
// and yields exactly one result transaction. The block takes one transaction
// per clock cycle while res_o.ready does not stall; a result passes through
// one input register and one result register, and the result register lets the
// next input enter while a result waits. The per-cycle path is the window
// logic: one peak-to-peak by reciprocal multiply and the trigger compare.
// Registers may be written only while no transaction is in flight.
module current_triggered_relay_controller_top #(
  parameter int unsigned ADC_BITS = 10,
  parameter int unsigned LAG_BITS = 24
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ctrc_in_if.sink    in_i,
  ctrc_cfg_if.sink   cfg_i,
  ctrc_out_if.source res_o
);

  localparam int unsigned LAG_W =
      (LAG_BITS > ctrc_pkg::LAG_RESET_W) ? LAG_BITS : ctrc_pkg::LAG_RESET_W;
  localparam logic [ctrc_pkg::CFG_DATA_W-1:0] LAG_MASK =
      ctrc_pkg::CFG_DATA_W'((64'd1 << LAG_BITS) - 64'd1);

  // Configuration registers.
  logic [ctrc_pkg::MA_W-1:0]       trigger_q;
  logic [ctrc_pkg::INTERVAL_W-1:0] interval_q;
  logic [ctrc_pkg::WINDOW_W-1:0]   window_q;
  logic [LAG_W-1:0]                flag_cfg_q;
  logic [LAG_W-1:0]                plag_cfg_q;

  // Input and result stages.
  logic                s1_valid_q;
  logic                s1_action_q;
  logic [ADC_BITS-1:0] s1_sample_q;
  logic                s1_adv;
  logic                step;
  logic                out_valid_q;

  ctrc_pkg::win_evt_t   evt;
  ctrc_pkg::relay_out_t relay;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trigger_q  <= ctrc_pkg::TRIGGER_RESET;
      interval_q <= ctrc_pkg::INTERVAL_RESET;
      window_q   <= ctrc_pkg::WINDOW_RESET;
      flag_cfg_q <= LAG_W'(ctrc_pkg::FOLLOWER_LAG_RESET);
      plag_cfg_q <= LAG_W'(ctrc_pkg::PULSE_LAG_RESET);
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        ctrc_pkg::CFG_TRIGGER_MA:   trigger_q  <= ctrc_pkg::MA_W'(cfg_i.data);
        ctrc_pkg::CFG_INTERVAL_MS:  interval_q <= ctrc_pkg::INTERVAL_W'(cfg_i.data);
        ctrc_pkg::CFG_WINDOW_MS:    window_q   <= ctrc_pkg::WINDOW_W'(cfg_i.data);
        ctrc_pkg::CFG_FOLLOWER_LAG: flag_cfg_q <= LAG_W'(cfg_i.data & LAG_MASK);
        ctrc_pkg::CFG_PULSE_LAG:    plag_cfg_q <= LAG_W'(cfg_i.data & LAG_MASK);
        default: ;
      endcase
    end
  end

  // The input stage moves on whenever the result register is free or drains.
  assign s1_adv     = !out_valid_q || res_o.ready;
  assign step       = s1_valid_q && s1_adv;
  assign in_i.ready = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_action_q <= in_i.action;
      s1_sample_q <= in_i.adc_sample;
    end
  end

  ctrc_window #(
    .ADC_BITS (ADC_BITS)
  ) u_window (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .action_i      (s1_action_q),
    .sample_i      (s1_sample_q),
    .interval_ms_i (interval_q),
    .window_ms_i   (window_q),
    .evt_o         (evt)
  );

  ctrc_relay #(
    .LAG_BITS (LAG_BITS)
  ) u_relay (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .tick_i         (s1_action_q),
    .evt_i          (evt),
    .trigger_ma_i   (trigger_q),
    .follower_lag_i (flag_cfg_q),
    .pulse_lag_i    (plag_cfg_q),
    .out_o          (relay)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_o.follower_relay     <= relay.follower_relay;
      res_o.follower_led       <= relay.follower_led;
      res_o.pulse_relay        <= relay.pulse_relay;
      res_o.pulse_led          <= relay.pulse_led;
      res_o.measured_milliamps <= evt.milliamps;
      res_o.measurement_done   <= evt.close;
    end
  end

  assign res_o.valid = out_valid_q;

endmodule

// File: hw/rtl/ctrc_window.sv
// ----------------------------------------------------------------------------
// ctrc_window
// Check interval and sampling window timing, min/max tracking and the
// peak-to-peak to RMS milliamp conversion.
// ----------------------------------------------------------------------------
module ctrc_window #(
  parameter int unsigned ADC_BITS = 10
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                step_i,
  input  logic                                action_i,
  input  logic [ADC_BITS-1:0]                 sample_i,
  input  logic [ctrc_pkg::INTERVAL_W-1:0]     interval_ms_i,
  input  logic [ctrc_pkg::WINDOW_W-1:0]       window_ms_i,
  output ctrc_pkg::win_evt_t                  evt_o
);

  localparam logic [ADC_BITS-1:0] ADC_MAX = {ADC_BITS{1'b1}};
  // floor(p2p * 7072 / ADC_MAX) as a multiply by a rounded-up reciprocal.
  // The shift of 2*ADC_BITS+1 keeps the error below one count for every p2p.
  localparam int unsigned SHIFT = 2 * ADC_BITS + 1;
  localparam int unsigned MUL_W = ADC_BITS + 15;
  localparam int unsigned PROD_W = ADC_BITS + MUL_W;
  localparam logic [MUL_W-1:0] SCALE_MUL = MUL_W'(
      ((64'(ctrc_pkg::RMS_FULL_SCALE) << SHIFT) / ((64'd1 << ADC_BITS) - 64'd1)) + 64'd1);

  logic                              sampling_q, sampling_d;
  logic [ctrc_pkg::WINDOW_W-1:0]     win_cnt_q, win_cnt_d;
  logic [ctrc_pkg::INTERVAL_W-1:0]   int_cnt_q, int_cnt_d;
  logic [ADC_BITS-1:0]               max_q, max_d;
  logic [ADC_BITS-1:0]               min_q, min_d;
  logic [ctrc_pkg::MA_W-1:0]         ma_q, ma_d;

  logic [ADC_BITS-1:0]               p2p;
  logic [PROD_W-1:0]                 prod;
  logic [ctrc_pkg::MA_W-1:0]         ma_new;
  logic [ctrc_pkg::WINDOW_W-1:0]     win_inc;
  logic [ctrc_pkg::INTERVAL_W-1:0]   int_inc;

  assign p2p    = (max_q >= min_q) ? (max_q - min_q) : '0;
  assign prod   = PROD_W'(p2p) * PROD_W'(SCALE_MUL);
  assign ma_new = ctrc_pkg::MA_W'(prod >> SHIFT);

  assign win_inc = (win_cnt_q != '1) ? win_cnt_q + 1'b1 : win_cnt_q;
  assign int_inc = (int_cnt_q != '1) ? int_cnt_q + 1'b1 : int_cnt_q;

  always_comb begin
    sampling_d = sampling_q;
    win_cnt_d  = win_cnt_q;
    int_cnt_d  = int_cnt_q;
    max_d      = max_q;
    min_d      = min_q;
    ma_d       = ma_q;
    evt_o      = '0;
    if (step_i) begin
      if (!action_i) begin
        if (sampling_q) begin
          if (sample_i > max_q) max_d = sample_i;
          if (sample_i < min_q) min_d = sample_i;
        end
      end else if (sampling_q) begin
        win_cnt_d = win_inc;
        if (win_inc >= window_ms_i) begin
          evt_o.close = 1'b1;
          ma_d        = ma_new;
          sampling_d  = 1'b0;
          int_cnt_d   = '0;
        end
      end else begin
        evt_o.idle_tick = 1'b1;
        int_cnt_d       = int_inc;
        if (int_inc >= interval_ms_i) begin
          sampling_d = 1'b1;
          win_cnt_d  = '0;
          max_d      = '0;
          min_d      = ADC_MAX;
        end
      end
    end
    evt_o.milliamps = ma_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sampling_q <= 1'b0;
      win_cnt_q  <= '0;
      int_cnt_q  <= '0;
      max_q      <= '0;
      min_q      <= ADC_MAX;
      ma_q       <= '0;
    end else begin
      sampling_q <= sampling_d;
      win_cnt_q  <= win_cnt_d;
      int_cnt_q  <= int_cnt_d;
      max_q      <= max_d;
      min_q      <= min_d;
      ma_q       <= ma_d;
    end
  end

endmodule

// File: hw/rtl/ctrc_relay.sv
// ----------------------------------------------------------------------------
// ctrc_relay
// Follower and pulse relay state, lag countdowns and the LED blink phase.
// ----------------------------------------------------------------------------
module ctrc_relay #(
  parameter int unsigned LAG_BITS = 24,
  localparam int unsigned LAG_W =
      (LAG_BITS > ctrc_pkg::LAG_RESET_W) ? LAG_BITS : ctrc_pkg::LAG_RESET_W
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                step_i,
  input  logic                                tick_i,
  input  ctrc_pkg::win_evt_t                  evt_i,
  input  logic [ctrc_pkg::MA_W-1:0]           trigger_ma_i,
  input  logic [LAG_W-1:0]                    follower_lag_i,
  input  logic [LAG_W-1:0]                    pulse_lag_i,
  output ctrc_pkg::relay_out_t                out_o
);

  localparam int unsigned CNT_W = LAG_W + 1;

  typedef enum logic [1:0] {
    MODE_OFF,
    MODE_ON,
    MODE_SHUTTING
  } mode_e;

  mode_e                        mode_q, mode_d;
  logic                         pulse_q, pulse_d;
  logic [CNT_W-1:0]             flag_q, flag_d;
  logic [CNT_W-1:0]             plag_q, plag_d;
  logic [ctrc_pkg::PHASE_W-1:0] phase_q, phase_d;
  logic                         blink;

  always_comb begin
    mode_d  = mode_q;
    pulse_d = pulse_q;
    flag_d  = flag_q;
    plag_d  = plag_q;
    phase_d = phase_q;
    if (step_i && tick_i) begin
      phase_d = (phase_q == ctrc_pkg::PHASE_LAST) ? '0 : phase_q + 1'b1;
    end
    if (step_i && evt_i.close) begin
      if (evt_i.milliamps >= trigger_ma_i) begin
        mode_d  = MODE_ON;
        pulse_d = 1'b0;
      end else if (mode_q == MODE_ON) begin
        mode_d  = MODE_SHUTTING;
        flag_d  = CNT_W'(follower_lag_i) + 1'b1;
        pulse_d = 1'b1;
        plag_d  = CNT_W'(pulse_lag_i) + 1'b1;
      end
    end
    if (step_i && evt_i.idle_tick) begin
      if (flag_q != '0) flag_d = flag_q - 1'b1;
      if (plag_q != '0) plag_d = plag_q - 1'b1;
    end
    // Expiry is checked after a window closes and on every tick outside a window.
    if (step_i && (evt_i.close || evt_i.idle_tick)) begin
      if (mode_d == MODE_SHUTTING && flag_d == '0) mode_d = MODE_OFF;
      if (plag_d == '0 && mode_d != MODE_ON) pulse_d = 1'b0;
    end
  end

  assign blink = (phase_d < ctrc_pkg::LED_ON_END) ||
                 ((phase_d > ctrc_pkg::LED_MID_LO) && (phase_d < ctrc_pkg::LED_MID_HI));

  always_comb begin
    out_o.follower_relay = (mode_d != MODE_OFF);
    unique case (mode_d)
      MODE_ON:       out_o.follower_led = 1'b1;
      MODE_SHUTTING: out_o.follower_led = blink;
      default:       out_o.follower_led = 1'b0;
    endcase
    out_o.pulse_relay = pulse_d;
    out_o.pulse_led   = pulse_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_OFF;
      pulse_q <= 1'b0;
      flag_q  <= '0;
      plag_q  <= '0;
      phase_q <= '0;
    end else begin
      mode_q  <= mode_d;
      pulse_q <= pulse_d;
      flag_q  <= flag_d;
      plag_q  <= plag_d;
      phase_q <= phase_d;
    end
  end

endmodule
